### src/ntc_pkg.sv
package ntc_pkg;

	localparam int TABLE_ENTRIES     = 141;
	localparam int ZERO_DEGREE_INDEX = 40;

	localparam int ADC_W    = 12;
	localparam int TEMP_W   = 11;
	localparam int FAULT_W  = 2;
	localparam int MARGIN_W = 8;
	localparam int IDX_W    = 8;
	localparam int NUM_W    = 16;
	localparam int QUO_W    = 4;

	localparam logic [MARGIN_W-1:0] MARGIN_RESET = 8'd35;

	localparam logic [FAULT_W-1:0] FAULT_NONE  = 2'd0;
	localparam logic [FAULT_W-1:0] FAULT_OPEN  = 2'd1;
	localparam logic [FAULT_W-1:0] FAULT_SHORT = 2'd2;

	localparam logic signed [TEMP_W-1:0] TEMP_COLD = TEMP_W'(-ZERO_DEGREE_INDEX * 10);
	localparam logic signed [TEMP_W-1:0] TEMP_HOT  =
		TEMP_W'((TABLE_ENTRIES - 1 - ZERO_DEGREE_INDEX) * 10);

	typedef logic [ADC_W-1:0] adc_t;

	typedef struct packed {
		logic             start;
		logic [NUM_W-1:0] num;
		logic [ADC_W-1:0] den;
	} div_req_t;

	localparam adc_t NTC_TABLE [0:TABLE_ENTRIES-1] = '{
		12'd3894, 12'd3883, 12'd3872, 12'd3860, 12'd3848,
		12'd3835, 12'd3822, 12'd3808, 12'd3794, 12'd3779,
		12'd3764, 12'd3748, 12'd3731, 12'd3714, 12'd3696,
		12'd3677, 12'd3658, 12'd3638, 12'd3618, 12'd3597,
		12'd3575, 12'd3553, 12'd3529, 12'd3506, 12'd3481,
		12'd3456, 12'd3430, 12'd3403, 12'd3376, 12'd3348,
		12'd3320, 12'd3291, 12'd3261, 12'd3230, 12'd3199,
		12'd3167, 12'd3135, 12'd3102, 12'd3069, 12'd3035,
		12'd3000, 12'd2966, 12'd2930, 12'd2894, 12'd2858,
		12'd2821, 12'd2784, 12'd2747, 12'd2709, 12'd2671,
		12'd2632, 12'd2594, 12'd2555, 12'd2516, 12'd2477,
		12'd2438, 12'd2399, 12'd2360, 12'd2320, 12'd2281,
		12'd2242, 12'd2203, 12'd2164, 12'd2125, 12'd2086,
		12'd2048, 12'd2009, 12'd1971, 12'd1933, 12'd1896,
		12'd1858, 12'd1821, 12'd1785, 12'd1749, 12'd1713,
		12'd1677, 12'd1642, 12'd1608, 12'd1574, 12'd1540,
		12'd1507, 12'd1474, 12'd1442, 12'd1410, 12'd1379,
		12'd1348, 12'd1318, 12'd1288, 12'd1259, 12'd1230,
		12'd1202, 12'd1175, 12'd1147, 12'd1121, 12'd1095,
		12'd1069, 12'd1044, 12'd1020, 12'd996,  12'd972,
		12'd949,  12'd927,  12'd905,  12'd883,  12'd862,
		12'd842,  12'd822,  12'd802,  12'd783,  12'd764,
		12'd746,  12'd728,  12'd711,  12'd694,  12'd677,
		12'd661,  12'd645,  12'd629,  12'd614,  12'd599,
		12'd585,  12'd571,  12'd557,  12'd544,  12'd531,
		12'd519,  12'd506,  12'd494,  12'd483,  12'd471,
		12'd460,  12'd449,  12'd438,  12'd428,  12'd418,
		12'd408,  12'd399,  12'd389,  12'd380,  12'd371,
		12'd363
	};

	// Entries past the end read as zero.
	function automatic adc_t table_entry(input logic [IDX_W-1:0] idx);
		adc_t ent;
		ent = '0;
		if ({1'b0, idx} < (IDX_W+1)'(TABLE_ENTRIES)) begin
			ent = NTC_TABLE[idx];
		end
		return ent;
	endfunction

endpackage

### src/ntc_div.sv
module ntc_div (
	input  logic                      clk,
	input  logic                      arst_n,
	input  ntc_pkg::div_req_t         req,
	output logic [ntc_pkg::QUO_W-1:0] quo,
	output logic                      done
);

	logic                      busy_q;
	logic                      done_q;
	logic [1:0]                step_q;
	logic [ntc_pkg::NUM_W-1:0] rem_q;
	logic [ntc_pkg::ADC_W-1:0] den_q;
	logic [ntc_pkg::QUO_W-1:0] quo_q;

	logic [ntc_pkg::NUM_W:0] trial;
	logic                    fits;

	// Restoring divide, one quotient bit per cycle, high bit first.
	assign trial = (ntc_pkg::NUM_W+1)'(den_q) << step_q;
	assign fits  = {1'b0, rem_q} >= trial;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				step_q <= 2'd3;
			end else if (busy_q) begin
				if (step_q == 2'd0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					step_q <= step_q - 2'd1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= req.num;
			den_q <= req.den;
			quo_q <= '0;
		end else if (busy_q && fits) begin
			rem_q         <= rem_q - trial[ntc_pkg::NUM_W-1:0];
			quo_q[step_q] <= 1'b1;
		end
	end

	assign quo  = quo_q;
	assign done = done_q;

endmodule

### src/ntc_adc_to_temperature_top.sv
// NTC reading to temperature in tenths of a degree, one item at a time.
// Faults, table ends and exact hits finish after the table search; other readings
// are interpolated, which adds the divider (8-step table search, 4-step divider).
// The input stalls while an item is in work, so a new item is taken only once the last is done.
// Reset clears the sequencer and output valid; the fault margin resets to 35.
module ntc_adc_to_temperature_top (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [ntc_pkg::MARGIN_W-1:0]        cfg_wdata,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic [ntc_pkg::ADC_W-1:0]           adc_value,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic signed [ntc_pkg::TEMP_W-1:0]   temp_tenths,
	output logic [ntc_pkg::FAULT_W-1:0]         fault
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SEARCH,
		ST_CHECK,
		ST_DIVIDE,
		ST_DONE
	} state_t;

	localparam int IW = ntc_pkg::IDX_W;
	localparam int TW = ntc_pkg::TEMP_W;

	state_t                          state_q;
	logic [ntc_pkg::MARGIN_W-1:0]    margin_q;
	ntc_pkg::adc_t                   adc_q;
	logic [ntc_pkg::FAULT_W-1:0]     fault_q;
	logic [IW-1:0]                   idx_q;
	logic [2:0]                      bit_q;
	logic                            upper_q;
	logic signed [TW-1:0]            temp_q;
	logic                            out_valid_q;
	logic signed [TW-1:0]            temp_out_q;
	logic [ntc_pkg::FAULT_W-1:0]     fault_out_q;

	logic                            accept;
	logic                            is_open;
	logic                            is_short;
	logic [IW-1:0]                   cand;
	logic                            cand_ok;
	ntc_pkg::adc_t                   ent_hi;
	ntc_pkg::adc_t                   ent_lo;
	logic                            upper;
	ntc_pkg::adc_t                   gap;
	logic signed [IW:0]              shifted;
	logic signed [IW:0]              shifted_adj;
	logic signed [TW:0]              shifted_x;
	logic signed [TW-1:0]            base;
	ntc_pkg::div_req_t               div_req;
	logic [ntc_pkg::QUO_W-1:0]       div_quo;
	logic                            div_done;
	logic signed [TW-1:0]            quo_ext;
	logic                            out_free;

	assign accept   = in_valid && !in_stall;
	assign in_stall = (state_q != ST_IDLE);
	assign out_free = !out_valid_q || !out_stall;

	// Fault limits; the short test adds the margin to avoid a negative limit.
	assign is_open  = {1'b0, adc_value} >
		(13'(ntc_pkg::table_entry(IW'(0))) + 13'(margin_q));
	assign is_short = ({1'b0, adc_value} + 13'(margin_q)) <
		13'(ntc_pkg::table_entry(IW'(ntc_pkg::TABLE_ENTRIES - 1)));

	// Search: idx ends as the count of entries above the reading.
	assign cand    = idx_q | (IW'(1) << bit_q);
	assign cand_ok = ({1'b0, cand} <= (IW+1)'(ntc_pkg::TABLE_ENTRIES)) &&
		(ntc_pkg::table_entry(cand - IW'(1)) > adc_q);

	assign ent_hi = ntc_pkg::table_entry(idx_q - IW'(1));
	assign ent_lo = ntc_pkg::table_entry(idx_q);
	assign upper  = {1'b0, idx_q} >= (IW+1)'(ntc_pkg::ZERO_DEGREE_INDEX + 1);
	assign gap    = upper ? (ent_hi - adc_q) : (adc_q - ent_lo);

	assign shifted     = $signed({1'b0, idx_q}) - $signed((IW+1)'(ntc_pkg::ZERO_DEGREE_INDEX));
	assign shifted_adj = upper ? (shifted - (IW+1)'(1)) : shifted;
	assign shifted_x   = (TW+1)'(shifted_adj);
	assign base        = TW'((shifted_x <<< 3) + (shifted_x <<< 1));

	always_comb begin
		div_req.start = (state_q == ST_CHECK) && (fault_q == ntc_pkg::FAULT_NONE) &&
			(idx_q != '0) && ({1'b0, idx_q} < (IW+1)'(ntc_pkg::TABLE_ENTRIES)) &&
			(adc_q != ent_lo);
		div_req.num   = ntc_pkg::NUM_W'({gap, 3'b000}) + ntc_pkg::NUM_W'({gap, 1'b0});
		div_req.den   = ent_hi - ent_lo;
	end

	ntc_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.quo    (div_quo),
		.done   (div_done)
	);

	assign quo_ext = TW'(div_quo);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			margin_q    <= ntc_pkg::MARGIN_RESET;
			adc_q       <= '0;
			fault_q     <= ntc_pkg::FAULT_NONE;
			idx_q       <= '0;
			bit_q       <= '0;
			upper_q     <= 1'b0;
			temp_q      <= '0;
			out_valid_q <= 1'b0;
			temp_out_q  <= '0;
			fault_out_q <= ntc_pkg::FAULT_NONE;
		end else begin
			if (cfg_we) begin
				margin_q <= cfg_wdata;
			end
			if ((state_q == ST_DONE) && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						adc_q   <= adc_value;
						idx_q   <= '0;
						bit_q   <= 3'(IW - 1);
						fault_q <= is_open  ? ntc_pkg::FAULT_OPEN  :
						           is_short ? ntc_pkg::FAULT_SHORT : ntc_pkg::FAULT_NONE;
						state_q <= ST_SEARCH;
					end
				end
				ST_SEARCH: begin
					if (cand_ok) begin
						idx_q <= cand;
					end
					if (bit_q == 3'd0) begin
						state_q <= ST_CHECK;
					end else begin
						bit_q <= bit_q - 3'd1;
					end
				end
				ST_CHECK: begin
					upper_q <= upper;
					state_q <= div_req.start ? ST_DIVIDE : ST_DONE;
					if (fault_q != ntc_pkg::FAULT_NONE) begin
						temp_q <= '0;
					end else if (idx_q == '0) begin
						temp_q <= ntc_pkg::TEMP_COLD;
					end else if ({1'b0, idx_q} >= (IW+1)'(ntc_pkg::TABLE_ENTRIES)) begin
						temp_q <= ntc_pkg::TEMP_HOT;
					end else if (upper && (adc_q == ent_lo)) begin
						// exact hit above zero: whole degrees of the entry itself
						temp_q <= base + $signed(TW'(10));
					end else begin
						temp_q <= base;
					end
				end
				ST_DIVIDE: begin
					if (div_done) begin
						temp_q  <= upper_q ? (temp_q + quo_ext) : (temp_q - quo_ext);
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					// Hold until the output register is free.
					if (out_free) begin
						temp_out_q  <= temp_q;
						fault_out_q <= fault_q;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign out_valid   = out_valid_q;
	assign temp_tenths = temp_out_q;
	assign fault       = fault_out_q;

endmodule
